>>> design/apm_pkg.sv
package apm_pkg;

  // Sizes
  localparam int MAG_W              = 32;
  localparam int ROOT_W             = 17;
  localparam int HISTORY_DEPTH_DEF  = 2;
  localparam int QUEUE_DEPTH        = 2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_KIND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN  = 2'd2;

  // Sample size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;

  // Sample kinds
  localparam logic [1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [1:0] KIND_SIGNED   = 2'd1;
  localparam logic [1:0] KIND_FLOAT    = 2'd2;

  // Float decode: magnitude = mantissa * (2^31 - 1) scaled by 2^(exp - 150)
  localparam int         SCALE_SHIFT  = 31;
  localparam int         PROD_W       = 24 + SCALE_SHIFT;
  localparam logic [7:0] EXP_SPECIAL  = 8'hff;
  localparam logic [7:0] EXP_OFFSET   = 8'd150;

  typedef struct packed {
    logic [1:0] size;
    logic [1:0] kind;
    logic       big_endian;
  } apm_cfg_t;

  typedef struct packed {
    logic [MAG_W-1:0]  chunk_peak;
    logic [ROOT_W-1:0] level_root;
    logic [ROOT_W-1:0] history_peak;
  } apm_result_t;

endpackage

>>> design/apm_queue.sv
module apm_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

>>> design/apm_front.sv
module apm_front (
  input  logic                     clk,
  input  logic                     rst,
  input  apm_pkg::apm_cfg_t        cfg,
  input  logic                     push,
  output logic                     full,
  input  logic [31:0]              raw_sample_word,
  input  logic                     chunk_end,
  output logic                     peak_push,
  output logic [apm_pkg::MAG_W-1:0] peak_data,
  input  logic                     peak_full
);

  import apm_pkg::*;

  // decode stage signals
  logic [7:0]        b0, b1, b2, b3;
  logic [15:0]       v16;
  logic [31:0]       v32;
  logic [MAG_W-1:0]  int_mag;
  logic              use_float;
  logic [7:0]        ex;
  logic [7:0]        ex_eff;
  logic [23:0]       man;
  logic [PROD_W-1:0] prod;

  // stage 1 registers
  logic              s1_valid;
  logic              s1_end;
  logic              s1_float;
  logic              s1_special;
  logic              s1_nan;
  logic [7:0]        s1_ex;
  logic [PROD_W-1:0] s1_prod;
  logic [MAG_W-1:0]  s1_int;

  // stage 1 logic
  logic [7:0]              up_amt;
  logic [7:0]              dn_amt;
  logic [PROD_W+MAG_W-1:0] wide_l;
  logic [PROD_W-1:0]       wide_r;
  logic [MAG_W-1:0]        flt_mag;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        max_val;
  logic [MAG_W-1:0]        run_max;
  logic                    accept;
  logic                    advance;

  // byte order and integer magnitude
  always_comb begin
    b0 = raw_sample_word[7:0];
    b1 = raw_sample_word[15:8];
    b2 = raw_sample_word[23:16];
    b3 = raw_sample_word[31:24];
    v16 = cfg.big_endian ? {b0, b1} : {b1, b0};
    v32 = cfg.big_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    int_mag   = '0;
    use_float = 1'b0;
    unique case (cfg.size)
      SIZE_8: begin
        if (cfg.kind == KIND_UNSIGNED) begin
          int_mag = {24'd0, b0};
        end else if (cfg.kind == KIND_SIGNED) begin
          int_mag = b0[7] ? (32'd256 - {24'd0, b0}) : {24'd0, b0};
        end
      end
      SIZE_16: begin
        if (cfg.kind == KIND_UNSIGNED) begin
          int_mag = {16'd0, v16};
        end else if (cfg.kind == KIND_SIGNED) begin
          int_mag = v16[15] ? (32'h0001_0000 - {16'd0, v16}) : {16'd0, v16};
        end
      end
      SIZE_32: begin
        if (cfg.kind == KIND_UNSIGNED) begin
          int_mag = v32;
        end else if (cfg.kind == KIND_SIGNED) begin
          int_mag = v32[31] ? (32'd0 - v32) : v32;
        end else if (cfg.kind == KIND_FLOAT) begin
          use_float = 1'b1;
        end
      end
      default: ;
    endcase
    // float fields; scale by 2^31 - 1 as shift and subtract
    ex     = v32[30:23];
    ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    man    = {(ex != 8'd0), v32[22:0]};
    prod   = {man, SCALE_SHIFT'(0)} - {SCALE_SHIFT'(0), man};
  end

  assign full    = s1_valid && s1_end && peak_full;
  assign accept  = push && !full;
  assign advance = s1_valid && !(s1_end && peak_full);

  // float magnitude: align by exponent, saturate above 32 bits
  always_comb begin
    up_amt  = s1_ex - EXP_OFFSET;
    dn_amt  = EXP_OFFSET - s1_ex;
    wide_l  = {{MAG_W{1'b0}}, s1_prod} << up_amt[4:0];
    wide_r  = s1_prod >> dn_amt;
    flt_mag = '0;
    if (s1_special) begin
      flt_mag = s1_nan ? '0 : '1;
    end else if (s1_prod == '0) begin
      flt_mag = '0;
    end else if (s1_ex >= EXP_OFFSET) begin
      if (up_amt > 8'd31 || (|wide_l[PROD_W+MAG_W-1:MAG_W])) begin
        flt_mag = '1;
      end else begin
        flt_mag = wide_l[MAG_W-1:0];
      end
    end else begin
      flt_mag = (|wide_r[PROD_W-1:MAG_W]) ? '1 : wide_r[MAG_W-1:0];
    end
    mag     = s1_float ? flt_mag : s1_int;
    max_val = (mag > run_max) ? mag : run_max;
  end

  assign peak_push = s1_valid && s1_end && !peak_full;
  assign peak_data = max_val;

  // stage 1 valid and running chunk maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      run_max  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        run_max <= s1_end ? '0 : max_val;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_end     <= chunk_end;
      s1_float   <= use_float;
      s1_special <= (ex == EXP_SPECIAL);
      s1_nan     <= |v32[22:0];
      s1_ex      <= ex_eff;
      s1_prod    <= prod;
      s1_int     <= int_mag;
    end
  end

endmodule

>>> design/apm_back.sv
module apm_back #(
  parameter int HISTORY_DEPTH = apm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      peak_empty,
  output logic                      peak_pop,
  input  logic [apm_pkg::MAG_W-1:0] peak_data,
  output logic                      res_push,
  output apm_pkg::apm_result_t      res_data,
  input  logic                      res_full
);

  import apm_pkg::*;

  localparam int PTR_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W      = 6;
  localparam int DIV_STEPS  = MAG_W + 1;
  localparam int SQRT_STEPS = (MAG_W + 2) / 2;
  localparam int QUOT_W     = MAG_W + 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int REM2_W     = SREM_W + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SQRT  = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [MAG_W-1:0]  peak;
  logic [MAG_W-1:0]  atp;
  logic [MAG_W-1:0]  atp_new;
  logic [MAG_W-1:0]  drem;
  logic [QUOT_W-1:0] quot;
  logic [SREM_W-1:0] srem;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] hist [HISTORY_DEPTH];
  logic [PTR_W-1:0]  ptr;
  logic [ROOT_W-1:0] hmax;

  logic              bit_in;
  logic [MAG_W:0]    dsh;
  logic [MAG_W:0]    ddiff;
  logic              dge;
  logic [REM2_W-1:0] rem2;
  logic [REM2_W-1:0] trial;
  logic [REM2_W-1:0] sdiff;
  logic              sge;

  // restoring divide step and square root digit step
  always_comb begin
    atp_new = (peak_data > atp) ? peak_data : atp;
    bit_in  = (cnt == '0) ? peak[0] : 1'b0;
    dsh     = {drem, bit_in};
    dge     = (dsh >= {1'b0, atp});
    ddiff   = dsh - {1'b0, atp};
    rem2    = {srem, quot[QUOT_W-1:QUOT_W-2]};
    trial   = {2'b00, root, 2'b01};
    sge     = (rem2 >= trial);
    sdiff   = rem2 - trial;
  end

  // largest history entry
  always_comb begin
    hmax = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hist[i] > hmax) begin
        hmax = hist[i];
      end
    end
  end

  assign peak_pop = (state == ST_IDLE) && !peak_empty;
  assign res_push = (state == ST_EMIT) && !res_full;

  assign res_data.chunk_peak   = peak;
  assign res_data.level_root   = root;
  assign res_data.history_peak = hmax;

  // sequencer, all-time peak and history ring
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      atp   <= '0;
      ptr   <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!peak_empty) begin
            atp   <= atp_new;
            cnt   <= '0;
            state <= (atp_new == '0) ? ST_STORE : ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_SQRT: begin
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_STORE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_STORE: begin
          hist[ptr] <= root;
          ptr       <= (ptr == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr + 1'b1;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: quotient then root of the quotient
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && !peak_empty) begin
      peak <= peak_data;
      drem <= {1'b0, peak_data[MAG_W-1:1]};
      quot <= '0;
      srem <= '0;
      root <= '0;
    end else if (state == ST_DIV) begin
      drem <= dge ? ddiff[MAG_W-1:0] : dsh[MAG_W-1:0];
      quot <= {quot[QUOT_W-2:0], dge};
    end else if (state == ST_SQRT) begin
      quot <= {quot[QUOT_W-3:0], 2'b00};
      srem <= sge ? sdiff[SREM_W-1:0] : rem2[SREM_W-1:0];
      root <= {root[ROOT_W-2:0], sge};
    end
  end

endmodule

>>> design/audio_peak_level_meter.sv
// Audio peak level meter. Samples enter at one per clock while full is low
// (push/full) and are decoded (8/16/32-bit, unsigned, signed or float, either
// byte order) into magnitudes; the running chunk maximum is kept as they pass.
// The sample flagged chunk_end hands the chunk peak through a two-entry
// queue to a sequencer that folds it into the all-time peak, divides one bit
// per cycle and takes the square root two bits per cycle, and takes the next
// peak only when the last result has been handed on. Results leave
// through a two-entry result queue read with empty/pop. Chunks shorter than
// the back-end time fill the peak queue and then hold full high until a
// slot frees. Configuration is taken on cfg_valid (cfg_ready is always high)
// and must only change while no samples are in flight.
module audio_peak_level_meter #(
  parameter int HISTORY_DEPTH = apm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [31:0]                     raw_sample_word,
  input  logic                            chunk_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [apm_pkg::MAG_W-1:0]       chunk_peak,
  output logic [apm_pkg::ROOT_W-1:0]      level_root,
  output logic [apm_pkg::ROOT_W-1:0]      history_peak,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [apm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [apm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import apm_pkg::*;

  apm_cfg_t          cfg;
  logic              peak_push;
  logic [MAG_W-1:0]  peak_wdata;
  logic              peak_full;
  logic              peak_pop;
  logic [MAG_W-1:0]  peak_rdata;
  logic              peak_empty;
  logic              res_push;
  apm_result_t       res_wdata;
  logic              res_full;
  apm_result_t       res_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size       <= SIZE_16;
      cfg.kind       <= KIND_SIGNED;
      cfg.big_endian <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SAMPLE_SIZE: cfg.size       <= cfg_data;
        CFG_SAMPLE_KIND: cfg.kind       <= cfg_data;
        CFG_BIG_ENDIAN:  cfg.big_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sample decode and chunk maximum
  apm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .push            (push),
    .full            (full),
    .raw_sample_word (raw_sample_word),
    .chunk_end       (chunk_end),
    .peak_push       (peak_push),
    .peak_data       (peak_wdata),
    .peak_full       (peak_full)
  );

  // chunk peaks waiting for the back end
  apm_queue #(
    .WIDTH (MAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_peak_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (peak_push),
    .wdata (peak_wdata),
    .full  (peak_full),
    .pop   (peak_pop),
    .rdata (peak_rdata),
    .empty (peak_empty)
  );

  // all-time peak, divide, root and history
  apm_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .peak_empty (peak_empty),
    .peak_pop   (peak_pop),
    .peak_data  (peak_rdata),
    .res_push   (res_push),
    .res_data   (res_wdata),
    .res_full   (res_full)
  );

  // finished results
  apm_queue #(
    .WIDTH ($bits(apm_result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign chunk_peak   = res_rdata.chunk_peak;
  assign level_root   = res_rdata.level_root;
  assign history_peak = res_rdata.history_peak;

endmodule

>>> bench/tb_audio_peak_level_meter.sv
`timescale 1ns / 1ps

import apm_pkg::*;

// Tracks the meter state, predicts one level result per chunk and checks what comes out
class level_scoreboard;
  logic [1:0]        size_code;
  logic [1:0]        kind;
  logic              big_end;
  logic [MAG_W-1:0]  chunk_max;
  logic [MAG_W-1:0]  loudest;
  logic [ROOT_W-1:0] level_ring [HISTORY_DEPTH_DEF];
  int unsigned       ring_slot;
  apm_result_t       expected_levels [$];
  int                errors;

  function new();
    size_code = SIZE_16;
    kind      = KIND_SIGNED;
    big_end   = 1'b0;
    chunk_max = '0;
    loudest   = '0;
    foreach (level_ring[i]) level_ring[i] = '0;
    ring_slot = 0;
    errors    = 0;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SAMPLE_SIZE: size_code = data;
      CFG_SAMPLE_KIND: kind = data;
      CFG_BIG_ENDIAN:  big_end = data[0];
      default: ;
    endcase
  endfunction

  // |x| * (2^31 - 1), floored, saturating; NaN reads as silence
  function logic [31:0] float_to_mag(logic [31:0] bits);
    logic [7:0]  ex;
    logic [63:0] mant;
    logic [63:0] prod;
    int          sh;
    ex   = bits[30:23];
    mant = {41'd0, bits[22:0]};
    if (ex == EXP_SPECIAL) return (mant != 0) ? 32'd0 : 32'hFFFF_FFFF;
    if (ex == 8'd0) begin
      sh = 1 - int'(EXP_OFFSET);
    end else begin
      mant[23] = 1'b1;
      sh = int'(ex) - int'(EXP_OFFSET);
    end
    prod = mant * 64'h7FFF_FFFF;
    if (prod == 0) return 32'd0;
    if (sh >= 0) begin
      if (sh > 31 || prod > (64'hFFFF_FFFF >> sh)) return 32'hFFFF_FFFF;
      prod = prod << sh;
      return prod[31:0];
    end
    if (-sh >= 64) return 32'd0;
    prod = prod >> (-sh);
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function logic [31:0] sample_magnitude(logic [31:0] word);
    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] v;
    b0 = word[7:0];
    b1 = word[15:8];
    b2 = word[23:16];
    b3 = word[31:24];
    case (size_code)
      SIZE_8: begin
        if (kind == KIND_UNSIGNED) return {24'd0, b0};
        if (kind == KIND_SIGNED) return b0[7] ? 32'd256 - {24'd0, b0} : {24'd0, b0};
        return 32'd0;
      end
      SIZE_16: begin
        v = big_end ? {16'd0, b0, b1} : {16'd0, b1, b0};
        if (kind == KIND_UNSIGNED) return v;
        if (kind == KIND_SIGNED) return v[15] ? 32'h1_0000 - v : v;
        return 32'd0;
      end
      SIZE_32: begin
        v = big_end ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
        if (kind == KIND_UNSIGNED) return v;
        if (kind == KIND_SIGNED) return v[31] ? 32'd0 - v : v;
        if (kind == KIND_FLOAT) return float_to_mag(v);
        return 32'd0;
      end
      default: return 32'd0;
    endcase
  endfunction

  // floor(sqrt(q)), one result bit at a time
  function logic [ROOT_W-1:0] root_q16(logic [63:0] q);
    logic [63:0] r, t;
    int          k;
    r = '0;
    for (k = 16; k >= 0; k--) begin
      t = r + (64'd1 << k);
      if (t * t <= q) r = t;
    end
    return r[ROOT_W-1:0];
  endfunction

  // Accepted sample request: fold into the chunk, close the chunk on chunk_end
  function void note_sample(logic [31:0] word, logic last);
    logic [31:0] mag;
    apm_result_t res;
    int          i;
    mag = sample_magnitude(word);
    if (mag > chunk_max) chunk_max = mag;
    if (!last) return;
    res.chunk_peak = chunk_max;
    chunk_max = '0;
    if (res.chunk_peak > loudest) loudest = res.chunk_peak;
    res.level_root = (loudest != 0) ? root_q16({res.chunk_peak, 32'd0} / loudest) : '0;
    level_ring[ring_slot] = res.level_root;
    ring_slot = (ring_slot + 1) % HISTORY_DEPTH_DEF;
    res.history_peak = '0;
    for (i = 0; i < HISTORY_DEPTH_DEF; i++)
      if (level_ring[i] > res.history_peak) res.history_peak = level_ring[i];
    expected_levels.push_back(res);
  endfunction

  function void check_result(logic [MAG_W-1:0] peak, logic [ROOT_W-1:0] root,
                             logic [ROOT_W-1:0] hist);
    apm_result_t want;
    if (expected_levels.size() == 0) begin
      $display("%0t: unexpected result peak %0d root %0d history %0d",
               $time, peak, root, hist);
      errors++;
      return;
    end
    want = expected_levels.pop_front();
    if (peak !== want.chunk_peak) begin
      $display("%0t: chunk_peak expected %0d, got %0d", $time, want.chunk_peak, peak);
      errors++;
    end
    if (root !== want.level_root) begin
      $display("%0t: level_root expected %0d, got %0d", $time, want.level_root, root);
      errors++;
    end
    if (hist !== want.history_peak) begin
      $display("%0t: history_peak expected %0d, got %0d", $time, want.history_peak, hist);
      errors++;
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module tb_audio_peak_level_meter;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          SETTLE       = 80;
  localparam int          TAIL         = 100;
  localparam int          HOLD_CYCLES  = 900;
  localparam int          PHASES       = 12;
  localparam int          PHASE_ITEMS  = 150;
  localparam logic [1:0]  SIZE_NONE    = 2'd3;
  localparam logic [1:0]  KIND_NONE    = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [31:0] raw_sample_word = '0;
  logic chunk_end = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic full, empty, cfg_ready;
  logic [MAG_W-1:0]  chunk_peak;
  logic [ROOT_W-1:0] level_root;
  logic [ROOT_W-1:0] history_peak;

  level_scoreboard sb;
  logic calm = 1'b0;
  logic reader_hold = 1'b0;
  int   cycle_count = 0;

  audio_peak_level_meter #(.HISTORY_DEPTH(HISTORY_DEPTH_DEF)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .raw_sample_word(raw_sample_word), .chunk_end(chunk_end),
    .empty(empty), .pop(pop),
    .chunk_peak(chunk_peak), .level_root(level_root), .history_peak(history_peak),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_audio_peak_level_meter: done, errors");
      $finish;
    end
  end

  // Observe every handshake at the edge it completes
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (push && !full) sb.note_sample(raw_sample_word, chunk_end);
      if (pop && !empty) sb.check_result(chunk_peak, level_root, history_peak);
    end
  end

  // Result reader: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (reader_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        reader_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // One sample request; push stays high for a following request
  task automatic send_sample(input logic [31:0] w, input logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    raw_sample_word <= w;
    chunk_end <= last;
    do @(posedge clk); while (full);
  endtask

  // drop push and wait for the clock first, so the last accepted request is already counted
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reformat only with the meter idle
  task automatic set_format(input logic [1:0] size, input logic [1:0] kind,
                            input logic [1:0] order);
    drain();
    repeat (SETTLE) @(posedge clk);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 2'($urandom));
    write_reg(CFG_SAMPLE_SIZE, size);
    write_reg(CFG_SAMPLE_KIND, kind);
    write_reg(CFG_BIG_ENDIAN, order);
    cfg_valid <= 1'b0;
  endtask

  function automatic int sample_width();
    case (sb.size_code)
      SIZE_8:  return 8;
      SIZE_16: return 16;
      default: return 32;
    endcase
  endfunction

  // Lay a value out in stream byte order for the current format
  function automatic logic [31:0] in_stream_order(logic [31:0] v);
    logic [31:0] w;
    w = $urandom;
    case (sb.size_code)
      SIZE_8:  w[7:0] = v[7:0];
      SIZE_16: w[15:0] = sb.big_end ? {v[7:0], v[15:8]} : v[15:0];
      default: w = sb.big_end ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] gen_sample();
    int          sel, width, k;
    logic [31:0] v;
    logic [7:0]  ex;
    sel = $urandom_range(0, 9);
    width = sample_width();
    if (sel < 4) return $urandom;
    if (sel < 6) begin
      // sign and range corners byte by byte
      for (k = 0; k < 4; k++)
        case ($urandom_range(0, 4))
          0: v[8*k +: 8] = 8'h00;
          1: v[8*k +: 8] = 8'h7F;
          2: v[8*k +: 8] = 8'h80;
          3: v[8*k +: 8] = 8'hFF;
          default: v[8*k +: 8] = 8'($urandom);
        endcase
      return v;
    end
    if (sel < 8) begin
      // quieter samples, so level roots spread out
      v = $urandom >> (32 - width + $urandom_range(0, width - 1));
      return in_stream_order(v);
    end
    case ($urandom_range(0, 5))
      0: ex = 8'h00;
      1: ex = EXP_SPECIAL;
      default: ex = 8'($urandom_range(100, 160));
    endcase
    v = {1'($urandom), ex, ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom)};
    return in_stream_order(v);
  endfunction

  function automatic int chunk_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 13) return $urandom_range(1, 8);
    if (r < 19) return $urandom_range(9, 60);
    return $urandom_range(61, 300);
  endfunction

  logic [1:0] plan_size  [6] = '{SIZE_8, SIZE_32, SIZE_16, SIZE_32, SIZE_32, SIZE_8};
  logic [1:0] plan_kind  [6] = '{KIND_UNSIGNED, KIND_FLOAT, KIND_SIGNED,
                                 KIND_SIGNED, KIND_FLOAT, KIND_SIGNED};
  logic [1:0] plan_order [6] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1};

  initial begin
    int         phase, items, len, i;
    logic       paused;
    logic [1:0] size, kind;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 16-bit signed little endian out of reset: silence first, then signed minimum
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_8000, 1'b0);
    send_sample(32'h1234_7FFF, 1'b1);
    send_sample(32'h0000_0100, 1'b1);
    send_sample(32'hABCD_FFFF, 1'b1);

    // 8-bit signed and unsigned
    set_format(SIZE_8, KIND_SIGNED, 2'd0);
    send_sample(32'h0000_0080, 1'b1);
    send_sample(32'hFFFF_FF7F, 1'b1);
    set_format(SIZE_8, KIND_UNSIGNED, 2'd0);
    send_sample(32'h0000_00FF, 1'b1);

    // 32-bit big endian signed minimum and maximum, then unsigned full scale
    set_format(SIZE_32, KIND_SIGNED, 2'd1);
    send_sample(32'h0000_0080, 1'b1);
    send_sample(32'hFFFF_FF7F, 1'b1);
    set_format(SIZE_32, KIND_UNSIGNED, 2'd0);
    send_sample(32'hFFFF_FFFF, 1'b1);

    // float: infinity, NaN, denormal, 1.0, 2.0, saturation, -0.5, smallest normal
    set_format(SIZE_32, KIND_FLOAT, 2'd0);
    send_sample(32'h7F80_0000, 1'b1);
    send_sample(32'h7FC0_0000, 1'b1);
    send_sample(32'h0000_0001, 1'b1);
    send_sample(32'h3F80_0000, 1'b1);
    send_sample(32'h4000_0000, 1'b1);
    send_sample(32'h4080_0000, 1'b1);
    send_sample(32'hBF00_0000, 1'b1);
    send_sample(32'h0080_0000, 1'b1);

    // formats the meter does not support read as zero
    set_format(SIZE_NONE, KIND_UNSIGNED, 2'd0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    set_format(SIZE_8, KIND_FLOAT, 2'd0);
    send_sample(32'h0000_0080, 1'b1);
    set_format(SIZE_32, KIND_NONE, 2'd1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    set_format(SIZE_16, KIND_FLOAT, 2'd0);
    send_sample(32'h0000_8000, 1'b1);

    // random chunks, one format per phase
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) begin
        set_format(plan_size[phase], plan_kind[phase], plan_order[phase]);
      end else begin
        size = ($urandom_range(0, 7) == 0) ? SIZE_NONE : 2'($urandom_range(0, 2));
        if (size == SIZE_32 && $urandom_range(0, 1) == 0) kind = KIND_FLOAT;
        else kind = ($urandom_range(0, 7) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
        set_format(size, kind, 2'($urandom));
      end
      if (phase >= PHASES - 2) calm = 1'b1;
      items = 0;
      paused = 1'b0;
      if (phase == 7) begin
        // reader holds off while short chunks pile up behind it
        reader_hold = 1'b1;
        for (i = 0; i < 30; i++) send_sample(gen_sample(), 1'b1);
        items = 30;
      end
      while (items < PHASE_ITEMS) begin
        if (phase == 3 && !paused && items >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        len = chunk_len();
        if (items + len > PHASE_ITEMS) len = PHASE_ITEMS - items;
        for (i = 0; i < len; i++) send_sample(gen_sample(), i == len - 1);
        items += len;
      end
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_audio_peak_level_meter: done, clean");
    end else begin
      $display("tb_audio_peak_level_meter: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/apm_pkg.sv
design/apm_queue.sv
design/apm_front.sv
design/apm_back.sv
design/audio_peak_level_meter.sv
bench/tb_audio_peak_level_meter.sv
